// ----- hdl/sgps_pkg.sv -----
package sgps_pkg;

    localparam int MAX_RADIUS_DEF      = 8;
    localparam int COORD_BITS_DEF      = 16;
    localparam int COEFF_FRAC_BITS_DEF = 14;
    localparam int INDEX_BITS_DEF      = 16;

    localparam int COEFF_BITS     = 16;
    localparam int COEFF_WORDS    = 5;
    localparam int CFG_DATA_BITS  = 64;
    localparam int CFG_INDEX_BITS = 3;
    localparam int RADIUS_BITS    = 4;
    localparam int POS_BITS       = 16;

    localparam logic [CFG_INDEX_BITS-1:0] REG_RADIUS  = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_WRAP    = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_COEFF_A = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_COEFF_B = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_COEFF_C = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_COEFF_D = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] REG_COEFF_E = 3'd6;

    typedef logic [COEFF_WORDS-1:0][CFG_DATA_BITS-1:0] coeff_words_t;

    typedef struct packed {
        logic                  valid;
        logic                  head_sel;
        logic                  zero;
        logic [COEFF_BITS-1:0] coeff;
    } mac_ctl_t;

    function automatic logic [COEFF_BITS-1:0] tap_coeff(input coeff_words_t w,
                                                        input logic [4:0] t);
        logic [CFG_DATA_BITS-1:0] sel;
        case (t[4:2])
            3'd0:    sel = w[0];
            3'd1:    sel = w[1];
            3'd2:    sel = w[2];
            3'd3:    sel = w[3];
            default: sel = w[4];
        endcase
        return sel[COEFF_BITS*t[1:0] +: COEFF_BITS];
    endfunction

endpackage

// ----- hdl/sgps_ram.sv -----
module sgps_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- hdl/sgps_mac.sv -----
module sgps_mac
    import sgps_pkg::*;
#(
    parameter int MAX_RADIUS      = MAX_RADIUS_DEF,
    parameter int COORD_BITS      = COORD_BITS_DEF,
    parameter int COEFF_FRAC_BITS = COEFF_FRAC_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      clear,
    input  mac_ctl_t                  ctl,
    input  logic [2*COORD_BITS-1:0]   win_rdata,
    input  logic [2*COORD_BITS-1:0]   head_rdata,
    output logic                      busy,
    output logic [COORD_BITS-1:0]     res_x,
    output logic [COORD_BITS-1:0]     res_y,
    output logic [COORD_BITS-1:0]     raw_x,
    output logic [COORD_BITS-1:0]     raw_y
);

    localparam int PROD_W = COORD_BITS + COEFF_BITS;
    localparam int ACC_W  = PROD_W + $clog2(2 * MAX_RADIUS + 2);
    localparam int QW     = ACC_W + 1;

    mac_ctl_t                s1_reg;
    logic                    s2_vld_reg;
    logic signed [PROD_W-1:0] px_reg, py_reg;
    logic [COORD_BITS-1:0]   rx_reg, ry_reg;
    logic signed [ACC_W-1:0] ax_reg, ay_reg;

    logic [2*COORD_BITS-1:0] data;
    logic signed [COORD_BITS-1:0] dx, dy;

    always_comb
    begin
        data = s1_reg.head_sel ? head_rdata : win_rdata;
        if (s1_reg.zero)
        begin
            data = '0;
        end
        dx = signed'(data[COORD_BITS-1:0]);
        dy = signed'(data[2*COORD_BITS-1:COORD_BITS]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg     <= '0;
            s2_vld_reg <= 1'b0;
        end
        else
        begin
            s1_reg     <= ctl;
            s2_vld_reg <= s1_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_reg.valid)
        begin
            px_reg <= dx * signed'(s1_reg.coeff);
            py_reg <= dy * signed'(s1_reg.coeff);
            rx_reg <= data[COORD_BITS-1:0];
            ry_reg <= data[2*COORD_BITS-1:COORD_BITS];
        end
        if (clear)
        begin
            ax_reg <= '0;
            ay_reg <= '0;
        end
        else if (s2_vld_reg)
        begin
            ax_reg <= ax_reg + ACC_W'(px_reg);
            ay_reg <= ay_reg + ACC_W'(py_reg);
        end
    end

    function automatic logic [COORD_BITS-1:0] round_sat(input logic signed [ACC_W-1:0] acc);
        logic signed [QW-1:0] v;
        logic signed [QW-1:0] q;
        logic fits;
        v = QW'(acc) + (QW'(1) <<< (COEFF_FRAC_BITS - 1));
        q = v >>> COEFF_FRAC_BITS;
        fits = (&q[QW-1:COORD_BITS-1]) || !(|q[QW-1:COORD_BITS-1]);
        return fits ? q[COORD_BITS-1:0] : {q[QW-1], {(COORD_BITS-1){~q[QW-1]}}};
    endfunction

    assign busy  = s1_reg.valid || s2_vld_reg;
    assign res_x = round_sat(ax_reg);
    assign res_y = round_sat(ay_reg);
    assign raw_x = rx_reg;
    assign raw_y = ry_reg;

endmodule

// ----- hdl/savitzky_golay_point_smoother.sv -----
// Savitzky-Golay point smoother: filters x and y of a run of 2D points with a
// (2r+1)-tap FIR whose Q2.14 taps are loaded through the configuration port.
// One request is taken at a time. A request is first written to the memories,
// then each result is planned and, when filtered, computed one tap per cycle
// from the single read port of the window memory into one multiplier per
// coordinate, drained from the multiply pipeline and put out; a result that
// is passed through takes the same steps with a single tap. Each empty part of
// the result list costs a planning step, and the output may wait for out_ready.
// The request that ends a run produces up to 2r+1 results;
// in wrap mode these come from the window memory and the run-head memory.
// Results wait in an output register while the next result is computed.
module savitzky_golay_point_smoother
    import sgps_pkg::*;
#(
    parameter int MAX_RADIUS      = MAX_RADIUS_DEF,
    parameter int COORD_BITS      = COORD_BITS_DEF,
    parameter int COEFF_FRAC_BITS = COEFF_FRAC_BITS_DEF,
    parameter int INDEX_BITS      = INDEX_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [COORD_BITS-1:0]     px,
    input  logic [COORD_BITS-1:0]     py,
    input  logic                      end_of_run,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [COORD_BITS-1:0]     qx,
    output logic [COORD_BITS-1:0]     qy,
    output logic [POS_BITS-1:0]       position,
    output logic                      run_done
);

    localparam int WIN_DEPTH  = 2 * MAX_RADIUS + 1;
    localparam int HEAD_DEPTH = 2 * MAX_RADIUS;
    localparam int WA         = $clog2(WIN_DEPTH);
    localparam int HA         = $clog2(HEAD_DEPTH);
    localparam int IW         = INDEX_BITS + 2;
    localparam int TW         = $clog2(2 * MAX_RADIUS + 2);
    localparam int DW         = 2 * COORD_BITS;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_WRITE = 6'b000010,
        ST_PLAN  = 6'b000100,
        ST_EMIT  = 6'b001000,
        ST_TAP   = 6'b010000,
        ST_DRAIN = 6'b100000
    } state_t;

    typedef enum logic [3:0] {
        SEG_NOW_PASS = 4'b0001,
        SEG_NOW_FILT = 4'b0010,
        SEG_END_TAIL = 4'b0100,
        SEG_END_HEAD = 4'b1000
    } seg_t;

    state_t state_reg, state_next;
    seg_t   seg_reg, seg_next;

    logic [RADIUS_BITS-1:0] radius_reg;
    logic                   wrap_mode_reg;
    coeff_words_t           coeff_reg;

    logic [COORD_BITS-1:0]  x_reg, y_reg;
    logic                   run_end_reg;
    logic [INDEX_BITS-1:0]  n_reg, count_reg;
    logic [WA-1:0]          wptr_reg, wptr_next;
    logic [WIN_DEPTH-1:0]   win_valid_reg;

    logic                   started_reg, started_next;
    logic signed [IW-1:0]   cur_reg, cur_next;
    logic signed [IW-1:0]   job_i_reg, job_i_next;
    logic                   job_filt_reg, job_filt_next;
    logic                   job_head_reg, job_head_next;
    logic                   found_reg, found_next;
    logic [TW-1:0]          tap_reg, tap_next;
    logic signed [IW-1:0]   k_reg, k_next;

    logic [COORD_BITS-1:0]  pend_x_reg, pend_y_reg;
    logic signed [IW-1:0]   pend_pos_reg;
    logic                   have_pend_reg, have_pend_next;

    logic [COORD_BITS-1:0]  qx_reg, qy_reg;
    logic [POS_BITS-1:0]    position_reg;
    logic                   run_done_reg, out_valid_reg;

    logic [RADIUS_BITS-1:0] r;
    logic signed [IW-1:0]   ns, rs, seg_lo, seg_hi, eff;
    logic                   seg_en, seg_filt, seg_head, seg_found;
    logic                   out_free, accept, mac_clear, last_tap;

    logic [WA-1:0]          win_raddr;
    logic [HA-1:0]          head_raddr;
    logic signed [IW-1:0]   win_d;
    logic signed [WA:0]     phys;
    logic                   head_sel, gt, lt, near;
    logic                   head_we;

    logic [DW-1:0]          win_rdata, head_rdata;
    mac_ctl_t               mac_ctl;
    logic                   mac_busy;
    logic [COORD_BITS-1:0]  res_x, res_y, raw_x, raw_y;

    assign r        = (radius_reg > RADIUS_BITS'(MAX_RADIUS)) ?
                      RADIUS_BITS'(MAX_RADIUS) : radius_reg;
    assign ns       = signed'({2'b00, n_reg});
    assign rs       = signed'(IW'(r));
    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign head_we  = (state_reg == ST_WRITE) && (ns < (rs <<< 1))
                      && (ns < IW'(HEAD_DEPTH));
    assign wptr_next = (wptr_reg == WA'(WIN_DEPTH - 1)) ? '0 : wptr_reg + 1'b1;

    // segment bounds of the result list
    always_comb
    begin
        seg_en   = 1'b0;
        seg_filt = 1'b0;
        seg_head = 1'b0;
        seg_lo   = ns;
        seg_hi   = ns;
        case (seg_reg)
            SEG_NOW_PASS:
            begin
                seg_en = !wrap_mode_reg && (ns < rs);
            end
            SEG_NOW_FILT:
            begin
                seg_en   = ns >= (rs <<< 1);
                seg_filt = 1'b1;
                seg_lo   = ns - rs;
                seg_hi   = ns - rs;
            end
            SEG_END_TAIL:
            begin
                seg_en = run_end_reg;
                if (!wrap_mode_reg)
                begin
                    if (ns >= (rs <<< 1) - 1)
                    begin
                        seg_lo = IW'(ns - rs + 1);
                    end
                    else if (ns >= rs)
                    begin
                        seg_lo = rs;
                    end
                    else
                    begin
                        seg_lo = IW'(ns + 1);
                    end
                end
                else if (ns < (rs <<< 1))
                begin
                    seg_head = 1'b1;
                    seg_lo   = '0;
                end
                else
                begin
                    seg_filt = 1'b1;
                    seg_lo   = IW'(ns - rs + 1);
                end
            end
            SEG_END_HEAD:
            begin
                seg_en   = run_end_reg && wrap_mode_reg && (ns >= (rs <<< 1));
                seg_filt = 1'b1;
                seg_lo   = '0;
                seg_hi   = IW'(rs - 1);
            end
            default:
            begin
                seg_en = 1'b0;
            end
        endcase
        eff       = started_reg ? cur_reg : seg_lo;
        seg_found = seg_en && (eff <= seg_hi);
    end

    // tap address generation
    always_comb
    begin
        gt       = k_reg > ns;
        lt       = k_reg < 0;
        near     = (ns - k_reg) < IW'(WIN_DEPTH);
        head_sel = job_head_reg || gt || (!lt && !near);
        if (job_head_reg || !gt)
        begin
            head_raddr = k_reg[HA-1:0];
        end
        else
        begin
            head_raddr = HA'(k_reg - ns - 1);
        end
        win_d     = lt ? IW'(-k_reg - 1) : (ns - k_reg);
        phys      = signed'({1'b0, wptr_reg}) - signed'({1'b0, win_d[WA-1:0]});
        if (phys < 0)
        begin
            phys = phys + (WA+1)'(WIN_DEPTH);
        end
        win_raddr = phys[WA-1:0];
    end

    assign last_tap = tap_reg == (job_filt_reg ? TW'({r, 1'b0}) : '0);

    always_comb
    begin
        mac_ctl.valid    = (state_reg == ST_TAP);
        mac_ctl.head_sel = head_sel;
        mac_ctl.zero     = !head_sel && !win_valid_reg[win_raddr];
        mac_ctl.coeff    = tap_coeff(coeff_reg, 5'(tap_reg));
    end

    always_comb
    begin
        state_next     = state_reg;
        seg_next       = seg_reg;
        started_next   = started_reg;
        cur_next       = cur_reg;
        job_i_next     = job_i_reg;
        job_filt_next  = job_filt_reg;
        job_head_next  = job_head_reg;
        found_next     = found_reg;
        tap_next       = tap_reg;
        k_next         = k_reg;
        have_pend_next = have_pend_reg;
        mac_clear      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                seg_next     = SEG_NOW_PASS;
                started_next = 1'b0;
                state_next   = ST_PLAN;
            end
            ST_PLAN:
            begin
                if (seg_found)
                begin
                    found_next    = 1'b1;
                    started_next  = 1'b1;
                    cur_next      = IW'(eff + 1);
                    job_i_next    = eff;
                    job_filt_next = seg_filt;
                    job_head_next = seg_head;
                    tap_next      = '0;
                    k_next        = seg_filt ? eff - rs : eff;
                    mac_clear     = 1'b1;
                    state_next    = have_pend_reg ? ST_EMIT : ST_TAP;
                end
                else
                begin
                    started_next = 1'b0;
                    case (seg_reg)
                        SEG_NOW_PASS: seg_next = SEG_NOW_FILT;
                        SEG_NOW_FILT: seg_next = SEG_END_TAIL;
                        SEG_END_TAIL: seg_next = SEG_END_HEAD;
                        default:
                        begin
                            found_next = 1'b0;
                            state_next = have_pend_reg ? ST_EMIT : ST_IDLE;
                        end
                    endcase
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    have_pend_next = 1'b0;
                    state_next     = found_reg ? ST_TAP : ST_IDLE;
                end
            end
            ST_TAP:
            begin
                tap_next = tap_reg + 1'b1;
                k_next   = IW'(k_reg + 1);
                if (last_tap)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!mac_busy)
                begin
                    have_pend_next = 1'b1;
                    state_next     = ST_PLAN;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            seg_reg       <= SEG_NOW_PASS;
            started_reg   <= 1'b0;
            found_reg     <= 1'b0;
            have_pend_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            run_done_reg  <= 1'b0;
            radius_reg    <= '0;
            wrap_mode_reg <= 1'b0;
            coeff_reg     <= coeff_words_t'(16384);
            count_reg     <= '0;
            wptr_reg      <= '0;
            win_valid_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            seg_reg       <= seg_next;
            started_reg   <= started_next;
            found_reg     <= found_next;
            have_pend_reg <= have_pend_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_RADIUS:  radius_reg    <= cfg_data[RADIUS_BITS-1:0];
                    REG_WRAP:    wrap_mode_reg <= cfg_data[0];
                    REG_COEFF_A: coeff_reg[0]  <= cfg_data;
                    REG_COEFF_B: coeff_reg[1]  <= cfg_data;
                    REG_COEFF_C: coeff_reg[2]  <= cfg_data;
                    REG_COEFF_D: coeff_reg[3]  <= cfg_data;
                    REG_COEFF_E: coeff_reg[4]  <= {48'd0, cfg_data[COEFF_BITS-1:0]};
                    default:     ;
                endcase
            end
            if (accept)
            begin
                if (end_of_run)
                begin
                    count_reg <= '0;
                end
                else if (count_reg != '1)
                begin
                    count_reg <= count_reg + 1'b1;
                end
            end
            if (state_reg == ST_WRITE)
            begin
                wptr_reg                 <= wptr_next;
                win_valid_reg[wptr_next] <= 1'b1;
            end
            if (state_reg == ST_EMIT && out_free)
            begin
                out_valid_reg <= 1'b1;
                run_done_reg  <= !found_reg && run_end_reg;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        job_i_reg    <= job_i_next;
        job_filt_reg <= job_filt_next;
        job_head_reg <= job_head_next;
        tap_reg      <= tap_next;
        k_reg        <= k_next;
        if (accept)
        begin
            x_reg       <= px;
            y_reg       <= py;
            run_end_reg <= end_of_run;
            n_reg       <= count_reg;
        end
        if (state_reg == ST_DRAIN && !mac_busy)
        begin
            pend_x_reg   <= job_filt_reg ? res_x : raw_x;
            pend_y_reg   <= job_filt_reg ? res_y : raw_y;
            pend_pos_reg <= job_i_reg;
        end
        if (state_reg == ST_EMIT && out_free)
        begin
            qx_reg       <= pend_x_reg;
            qy_reg       <= pend_y_reg;
            position_reg <= POS_BITS'(pend_pos_reg[INDEX_BITS-1:0]);
        end
    end

    sgps_ram #(
        .WIDTH (DW),
        .DEPTH (WIN_DEPTH)
    ) u_win_ram (
        .clk   (clk),
        .we    (state_reg == ST_WRITE),
        .waddr (wptr_next),
        .wdata ({y_reg, x_reg}),
        .re    (state_reg == ST_TAP),
        .raddr (win_raddr),
        .rdata (win_rdata)
    );

    sgps_ram #(
        .WIDTH (DW),
        .DEPTH (HEAD_DEPTH)
    ) u_head_ram (
        .clk   (clk),
        .we    (head_we),
        .waddr (n_reg[HA-1:0]),
        .wdata ({y_reg, x_reg}),
        .re    (state_reg == ST_TAP),
        .raddr (head_raddr),
        .rdata (head_rdata)
    );

    sgps_mac #(
        .MAX_RADIUS      (MAX_RADIUS),
        .COORD_BITS      (COORD_BITS),
        .COEFF_FRAC_BITS (COEFF_FRAC_BITS)
    ) u_mac (
        .clk        (clk),
        .rst_n      (rst_n),
        .clear      (mac_clear),
        .ctl        (mac_ctl),
        .win_rdata  (win_rdata),
        .head_rdata (head_rdata),
        .busy       (mac_busy),
        .res_x      (res_x),
        .res_y      (res_y),
        .raw_x      (raw_x),
        .raw_y      (raw_y)
    );

    assign out_valid = out_valid_reg;
    assign qx        = qx_reg;
    assign qy        = qy_reg;
    assign position  = position_reg;
    assign run_done  = run_done_reg;

    a_accept_write: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == ST_WRITE)
        else $error("request not followed by store write");

    a_mac_busy: assert property (@(posedge clk) disable iff (!rst_n)
        mac_busy |-> (state_reg == ST_TAP || state_reg == ST_DRAIN))
        else $error("multiply pipeline active outside tap sequence");

    a_emit_pend: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT |-> have_pend_reg)
        else $error("emit without pending result");

    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && out_free && !found_reg && run_end_reg)
        |=> (out_valid_reg && run_done_reg))
        else $error("final result of run not flagged");

endmodule
